// File: src/windowed_peak_gauge_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed peak gauge tracker
// Clocked concurrent assertion forms, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PEAK_GAUGE_TRACKER_UNIT_ASSERT_SVH
`define WINDOWED_PEAK_GAUGE_TRACKER_UNIT_ASSERT_SVH

// check prop at every rising edge of ck while rst_n is high
`define WPGT_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// check prop at every rising edge of ck, reset included
`define WPGT_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// File: src/wpgt_pkg.sv
// ----------------------------------------------------------------------------
// wpgt_pkg
// Event kinds, window indexes and stream widths of the peak gauge tracker.
// ----------------------------------------------------------------------------
package wpgt_pkg;

	typedef enum logic [2:0] {
		KIND_INC   = 3'd0,
		KIND_DEC   = 3'd1,
		KIND_SET   = 3'd2,
		KIND_RESET = 3'd3,
		KIND_AVG   = 3'd4
	} kind_t;

	localparam int NUM_WIN       = 4;
	localparam int NUM_RESET_WIN = 3;
	localparam int WIN_ALL       = 3;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int MASK_W   = 3;
	localparam int TIME_W   = 32;
	localparam int TOTAL_W  = 64;
	localparam int WIDE_W   = 64;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 32;

	localparam int NV_LSB   = 0;
	localparam int MASK_LSB = NV_LSB + VALUE_W;
	localparam int NOW_LSB  = MASK_LSB + MASK_W;

endpackage

// File: src/windowed_peak_gauge_tracker_unit.sv
// ----------------------------------------------------------------------------
// windowed_peak_gauge_tracker_unit
// Gauge with daily, weekly, monthly and all-time peak, total and average.
// ----------------------------------------------------------------------------
// Takes one event item per clock while the result side is not stalled and
// returns one result item per event, through the input register and then the
// result register. An accepted event sits in the input register, where the
// gauge update and the peak, total and average updates of all four windows are
// worked out in parallel and written back together with the result register;
// back-to-back events therefore see each other's state with no gap. Result kind
// flag (tuser) is the all-time record bit, tdata the low 32 bits of the gauge
// after the event. Event kinds five to seven leave all state untouched.
module windowed_peak_gauge_tracker_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] new_value, [34:32] window_mask, [66:35] now, [71:67] zero
	input  logic [wpgt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] kind
	input  logic [wpgt_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] gauge
	output logic [wpgt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// [0] record
	output logic                            m_axis_tuser
);

	localparam int CW  = COUNT_WIDTH;
	localparam int NW  = wpgt_pkg::NUM_WIN;
	localparam int WW  = wpgt_pkg::WIDE_W;
	localparam logic [CW-1:0] GMAX    = '1;
	localparam logic [WW-1:0] GMAX_64 = {{(WW-CW){1'b0}}, GMAX};

	logic                          valid_s1;
	wpgt_pkg::kind_t               kind_s1;
	logic [wpgt_pkg::VALUE_W-1:0]  nv_s1;
	logic [wpgt_pkg::MASK_W-1:0]   mask_s1;
	logic [wpgt_pkg::TIME_W-1:0]   now_s1;

	logic                          m_valid_q;
	logic                          m_record_q;
	logic [wpgt_pkg::M_TDATA_W-1:0] m_gauge_q;

	logic [CW-1:0]                 gauge_q;
	logic [CW-1:0]                 peak_q      [NW];
	logic [wpgt_pkg::TIME_W-1:0]   peak_time_q [NW];
	logic [wpgt_pkg::TOTAL_W-1:0]  total_q     [NW];
	logic [CW-1:0]                 avg_q       [NW];

	logic                          advance;
	logic [CW-1:0]                 gauge_nx;
	logic [CW-1:0]                 peak_nx      [NW];
	logic [wpgt_pkg::TIME_W-1:0]   peak_time_nx [NW];
	logic [wpgt_pkg::TOTAL_W-1:0]  total_nx     [NW];
	logic [CW-1:0]                 avg_nx       [NW];
	logic                          record_nx;
	logic [WW-1:0]                 gauge_nx_64;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !m_valid_q || m_axis_tready;

	always_comb begin
		logic [WW-1:0]                nv_64;
		logic [CW-1:0]                nv_sat;
		logic [wpgt_pkg::TOTAL_W-1:0] add_amt;
		logic [NW-1:0]                reset_sel;
		logic                         track;
		logic                         do_reset;
		logic                         do_avg;
		logic [CW:0]                  avg_sum;

		nv_64     = {{(WW-wpgt_pkg::VALUE_W){1'b0}}, nv_s1};
		nv_sat    = (nv_64 > GMAX_64) ? GMAX : nv_64[CW-1:0];
		add_amt   = '0;
		reset_sel = {{(NW-wpgt_pkg::MASK_W){1'b0}}, mask_s1};
		track     = 1'b0;
		do_reset  = 1'b0;
		do_avg    = 1'b0;
		gauge_nx  = gauge_q;
		avg_sum   = '0;

		case (kind_s1)
			wpgt_pkg::KIND_INC: begin
				gauge_nx = (gauge_q == GMAX) ? gauge_q : gauge_q + 1'b1;
				add_amt  = {{(wpgt_pkg::TOTAL_W-1){1'b0}}, 1'b1};
				track    = 1'b1;
			end
			wpgt_pkg::KIND_DEC: begin
				gauge_nx = (gauge_q == '0) ? gauge_q : gauge_q - 1'b1;
			end
			wpgt_pkg::KIND_SET: begin
				gauge_nx = nv_sat;
				if (nv_sat > gauge_q) begin
					add_amt = {{(wpgt_pkg::TOTAL_W-CW){1'b0}}, nv_sat - gauge_q};
				end
				track = 1'b1;
			end
			wpgt_pkg::KIND_RESET: begin
				do_reset = 1'b1;
			end
			wpgt_pkg::KIND_AVG: begin
				do_avg = 1'b1;
			end
			default: begin
			end
		endcase

		for (int w = 0; w < NW; w++) begin
			peak_nx[w]      = peak_q[w];
			peak_time_nx[w] = peak_time_q[w];
			total_nx[w]     = total_q[w] + add_amt;
			avg_nx[w]       = avg_q[w];
			if (track) begin
				if (gauge_nx >= peak_q[w]) begin
					peak_nx[w]      = gauge_nx;
					peak_time_nx[w] = now_s1;
				end
			end
			if (do_reset && reset_sel[w]) begin
				peak_nx[w]      = gauge_q;
				peak_time_nx[w] = now_s1;
				total_nx[w]     = {{(wpgt_pkg::TOTAL_W-CW){1'b0}}, gauge_q};
			end
			if (do_avg) begin
				avg_sum   = {1'b0, peak_q[w]} + {1'b0, gauge_q};
				avg_nx[w] = avg_sum[CW:1];
			end
		end

		record_nx   = track && (gauge_nx > peak_q[wpgt_pkg::WIN_ALL]);
		gauge_nx_64 = {{(WW-CW){1'b0}}, gauge_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= wpgt_pkg::kind_t'(s_axis_tuser);
			nv_s1   <= s_axis_tdata[wpgt_pkg::NV_LSB +: wpgt_pkg::VALUE_W];
			mask_s1 <= s_axis_tdata[wpgt_pkg::MASK_LSB +: wpgt_pkg::MASK_W];
			now_s1  <= s_axis_tdata[wpgt_pkg::NOW_LSB +: wpgt_pkg::TIME_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_record_q <= record_nx;
			m_gauge_q  <= gauge_nx_64[wpgt_pkg::M_TDATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gauge_q <= '0;
			for (int w = 0; w < NW; w++) begin
				peak_q[w]      <= '0;
				peak_time_q[w] <= '0;
				total_q[w]     <= '0;
				avg_q[w]       <= '0;
			end
		end else if (advance) begin
			gauge_q <= gauge_nx;
			for (int w = 0; w < NW; w++) begin
				peak_q[w]      <= peak_nx[w];
				peak_time_q[w] <= peak_time_nx[w];
				total_q[w]     <= total_nx[w];
				avg_q[w]       <= avg_nx[w];
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_gauge_q;
	assign m_axis_tuser  = m_record_q;

endmodule

// File: src/wpgt_checker.sv
// ----------------------------------------------------------------------------
// wpgt_checker
// Port-level checks of the peak gauge tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_peak_gauge_tracker_unit_assert.svh"

module wpgt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [wpgt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic                            m_axis_tuser
);

	`WPGT_ASSERT_ALWAYS(a_rst_out_idle, clk, !arst_n |=> !m_axis_tvalid, "result valid in reset")
	`WPGT_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`WPGT_ASSERT(a_latency, clk, arst_n, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid, "no result two cycles after an item")
	`WPGT_ASSERT(a_stall_cause, clk, arst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule

bind windowed_peak_gauge_tracker_unit wpgt_checker u_wpgt_checker (.*);

// File: tb/tb_windowed_peak_gauge_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_peak_gauge_tracker_unit
// Stream testbench for the windowed peak gauge tracker.
// ----------------------------------------------------------------------------
// A queue of gauge events is filled up front. It holds directed corner cases
// (empty gauge, saturation, equal and lower sets, single-window, empty and full
// reset masks, unused kinds) and a long random run whose set values climb slowly, so new all-time
// peaks keep occurring. A clocked driver feeds the events with random gaps and
// updates a shadow copy of the gauge and of the four windows on each accepted
// item. A clocked monitor stalls the result side at random and checks every
// result item against the oldest predicted gauge and record flag.
// ----------------------------------------------------------------------------
module tb_windowed_peak_gauge_tracker_unit;

	localparam int RANDOM_EVENTS = 1880;
	localparam int TAIL_ITEMS    = 150;

	typedef struct packed {
		logic [wpgt_pkg::KIND_W-1:0]  kind;
		logic [wpgt_pkg::VALUE_W-1:0] level;
		logic [wpgt_pkg::MASK_W-1:0]  mask;
		logic [wpgt_pkg::TIME_W-1:0]  stamp;
		logic                         drain_first;
	} gauge_event_t;

	typedef struct packed {
		logic                         record;
		logic [wpgt_pkg::VALUE_W-1:0] level;
	} gauge_report_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [wpgt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [wpgt_pkg::KIND_W-1:0]    s_axis_tuser = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [wpgt_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;

	gauge_event_t  event_queue[$];
	gauge_report_t gauge_reports[$];
	gauge_event_t  live_event;
	gauge_report_t fresh_report;
	gauge_report_t want;
	int            gap_left = 0;
	int            stall_left = 0;
	int            failures = 0;

	logic [wpgt_pkg::VALUE_W-1:0] gauge_level = '0;
	logic [wpgt_pkg::VALUE_W-1:0] win_peak[wpgt_pkg::NUM_WIN] = '{default: '0};
	logic [wpgt_pkg::TIME_W-1:0]  win_peak_at[wpgt_pkg::NUM_WIN] = '{default: '0};
	logic [wpgt_pkg::TOTAL_W-1:0] win_total[wpgt_pkg::NUM_WIN] = '{default: '0};
	logic [wpgt_pkg::VALUE_W-1:0] win_avg[wpgt_pkg::NUM_WIN] = '{default: '0};

	windowed_peak_gauge_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void add_to_totals(input logic [wpgt_pkg::TOTAL_W-1:0] amount);
		for (int w = 0; w < wpgt_pkg::NUM_WIN; w++)
			win_total[w] = win_total[w] + amount;
	endfunction

	function automatic logic refresh_peaks(input logic [wpgt_pkg::TIME_W-1:0] stamp);
		logic rec;
		rec = 1'b0;
		for (int w = 0; w < wpgt_pkg::NUM_WIN; w++) begin
			if (gauge_level > win_peak[w]) begin
				win_peak[w] = gauge_level;
				win_peak_at[w] = stamp;
				if (w == wpgt_pkg::WIN_ALL)
					rec = 1'b1;
			end else if (gauge_level == win_peak[w]) begin
				win_peak_at[w] = stamp;
			end
		end
		return rec;
	endfunction

	function automatic gauge_report_t apply_gauge_event(input gauge_event_t ev);
		gauge_report_t rep;
		logic [wpgt_pkg::VALUE_W:0] sum;
		rep.record = 1'b0;
		case (ev.kind)
			wpgt_pkg::KIND_INC: begin
				if (gauge_level != '1)
					gauge_level = gauge_level + 1'b1;
				add_to_totals(64'd1);
				rep.record = refresh_peaks(ev.stamp);
			end
			wpgt_pkg::KIND_DEC: begin
				if (gauge_level != '0)
					gauge_level = gauge_level - 1'b1;
			end
			wpgt_pkg::KIND_SET: begin
				if (ev.level > gauge_level)
					add_to_totals(wpgt_pkg::TOTAL_W'(ev.level - gauge_level));
				gauge_level = ev.level;
				rep.record = refresh_peaks(ev.stamp);
			end
			wpgt_pkg::KIND_RESET: begin
				for (int w = 0; w < wpgt_pkg::NUM_RESET_WIN; w++) begin
					if (ev.mask[w]) begin
						win_peak[w] = gauge_level;
						win_total[w] = wpgt_pkg::TOTAL_W'(gauge_level);
						win_peak_at[w] = ev.stamp;
					end
				end
			end
			wpgt_pkg::KIND_AVG: begin
				for (int w = 0; w < wpgt_pkg::NUM_WIN; w++) begin
					sum = {1'b0, win_peak[w]} + {1'b0, gauge_level};
					win_avg[w] = sum[wpgt_pkg::VALUE_W:1];
				end
			end
			default: begin
			end
		endcase
		rep.level = gauge_level;
		return rep;
	endfunction

	task automatic add_event(input logic [wpgt_pkg::KIND_W-1:0] kind,
			input logic [wpgt_pkg::VALUE_W-1:0] level,
			input logic [wpgt_pkg::MASK_W-1:0] mask, input logic [wpgt_pkg::TIME_W-1:0] stamp,
			input logic drain_first = 1'b0);
		gauge_event_t ev;
		ev.kind = kind;
		ev.level = level;
		ev.mask = mask;
		ev.stamp = stamp;
		ev.drain_first = drain_first;
		event_queue.push_back(ev);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				fresh_report = apply_gauge_event(live_event);
				gauge_reports.push_back(fresh_report);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (event_queue.size() > 0 &&
						!(event_queue[0].drain_first && gauge_reports.size() > 0)) begin
					live_event = event_queue.pop_front();
					s_axis_tdata <= {5'b0, live_event.stamp, live_event.mask, live_event.level};
					s_axis_tuser <= live_event.kind;
					s_axis_tvalid <= 1'b1;
					if (event_queue.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0)
						gap_left = $urandom_range(1, 10);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (gauge_reports.size() == 0) begin
					$error("unexpected result item: gauge %0h record %0b",
						m_axis_tdata, m_axis_tuser);
					failures++;
				end else begin
					want = gauge_reports.pop_front();
					if (m_axis_tdata !== want.level) begin
						$error("gauge mismatch: expected %0h, got %0h", want.level, m_axis_tdata);
						failures++;
					end
					if (m_axis_tuser !== want.record) begin
						$error("record mismatch: expected %0b, got %0b",
							want.record, m_axis_tuser);
						failures++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (event_queue.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [wpgt_pkg::VALUE_W-1:0] base;
		logic [wpgt_pkg::VALUE_W-1:0] value;
		logic [wpgt_pkg::TIME_W-1:0]  clock_s;
		logic [wpgt_pkg::TIME_W-1:0]  stamp;
		int                           pick;

		add_event(wpgt_pkg::KIND_DEC, '1, 3'b111, 32'd1);
		add_event(wpgt_pkg::KIND_INC, '0, 3'b000, 32'd2);
		add_event(wpgt_pkg::KIND_INC, 32'h5a5a5a5a, 3'b101, 32'd3);
		add_event(wpgt_pkg::KIND_DEC, '0, 3'b000, 32'd4);
		add_event(wpgt_pkg::KIND_SET, 32'd6, 3'b010, 32'd5);
		add_event(wpgt_pkg::KIND_SET, 32'd6, 3'b000, 32'd6);
		add_event(wpgt_pkg::KIND_SET, 32'd3, 3'b000, 32'd7);
		add_event(wpgt_pkg::KIND_RESET, '0, 3'b001, 32'd8);
		add_event(wpgt_pkg::KIND_RESET, '0, 3'b010, 32'd9);
		add_event(wpgt_pkg::KIND_RESET, '0, 3'b100, 32'd10);
		add_event(wpgt_pkg::KIND_RESET, '0, 3'b000, 32'd11);
		add_event(wpgt_pkg::KIND_AVG, '1, 3'b111, '1);
		add_event(3'd5, '1, 3'b111, '1);
		add_event(3'd6, 32'd1, 3'b000, 32'd12);
		add_event(3'd7, '0, 3'b111, 32'd13);
		add_event(wpgt_pkg::KIND_SET, 32'd8, 3'b000, 32'd14);

		base = 32'd8;
		clock_s = 32'd20;
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			pick = $urandom_range(0, 99);
			clock_s = clock_s + $urandom_range(0, 5);
			stamp = ($urandom_range(0, 31) == 0) ? $urandom : clock_s;
			base = base + $urandom_range(0, 2);
			if (i >= RANDOM_EVENTS - 80)
				value = $urandom;
			else if ($urandom_range(0, 3) == 0)
				value = base - $urandom_range(0, 6);
			else
				value = base + $urandom_range(0, 6);
			if (pick < 32)
				add_event(wpgt_pkg::KIND_INC, $urandom, wpgt_pkg::MASK_W'($urandom), stamp,
					i % 500 == 250);
			else if (pick < 52)
				add_event(wpgt_pkg::KIND_DEC, $urandom, wpgt_pkg::MASK_W'($urandom), stamp,
					i % 500 == 250);
			else if (pick < 77)
				add_event(wpgt_pkg::KIND_SET, value, wpgt_pkg::MASK_W'($urandom), stamp,
					i % 500 == 250);
			else if (pick < 87)
				add_event(wpgt_pkg::KIND_RESET, $urandom, wpgt_pkg::MASK_W'($urandom), stamp,
					i % 500 == 250);
			else if (pick < 95)
				add_event(wpgt_pkg::KIND_AVG, $urandom, wpgt_pkg::MASK_W'($urandom), stamp,
					i % 500 == 250);
			else
				add_event(wpgt_pkg::KIND_W'($urandom_range(5, 7)), $urandom,
					wpgt_pkg::MASK_W'($urandom), stamp, i % 500 == 250);
		end

		add_event(wpgt_pkg::KIND_SET, '1, 3'b000, '1);
		add_event(wpgt_pkg::KIND_INC, '0, 3'b000, clock_s + 1);
		add_event(wpgt_pkg::KIND_SET, '1, 3'b000, clock_s + 2);
		add_event(wpgt_pkg::KIND_SET, 32'd100, 3'b000, clock_s + 3);
		add_event(wpgt_pkg::KIND_RESET, '0, 3'b111, clock_s + 4);
		add_event(wpgt_pkg::KIND_AVG, '0, 3'b000, clock_s + 5);
		add_event(wpgt_pkg::KIND_SET, '1, 3'b000, clock_s + 6);
		add_event(wpgt_pkg::KIND_AVG, '0, 3'b000, clock_s + 7);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (event_queue.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (gauge_reports.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
